// ===== sv/cvl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared types and constants for the compacting value list.
// ----------------------------------------------------------------------------
package cvl_pkg;

   localparam int COMMAND_W   = 2;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int INDEX_OUT_W = 7;
   localparam int OCC_OUT_W   = 8;
   localparam int GROUP_SIZE  = 16;
   localparam int LOC_W       = $clog2(GROUP_SIZE);

   typedef enum logic [COMMAND_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_MODIFY = 2'd3
   } cvl_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_NOMATCH = 2'd3
   } cvl_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_GROUP,
      S_RESOLVE,
      S_COMMIT
   } cvl_state_type;

   typedef struct packed {
      logic load;
      logic match;
      logic group;
      logic resolve;
      logic commit;
   } cvl_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/cvl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_datapath
// Entry cells, parallel compare, registered first-match tree and update logic.
// ----------------------------------------------------------------------------
module cvl_datapath
   import cvl_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cvl_ctrl_type           ctrl,
   input  logic [COMMAND_W-1:0]   req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic signed [VALUE_W-1:0] req_new_value,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [INDEX_OUT_W-1:0] rsp_match_index,
   output logic [OCC_OUT_W-1:0]   rsp_occupancy
);

   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD        = NUM_GROUPS * GROUP_SIZE;

   cvl_cmd_type          command_ff;
   logic [VALUE_W-1:0]   key_ff;
   logic [VALUE_W-1:0]   new_value_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [VALUE_W-1:0]   entries_ff [DEPTH];
   logic [PAD-1:0]       match_ff, match_in;
   logic [NUM_GROUPS-1:0] group_hit_ff, group_hit_in;
   logic [LOC_W-1:0]     group_loc_ff [NUM_GROUPS];
   logic [LOC_W-1:0]     group_loc_in [NUM_GROUPS];
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_index_ff, hit_index_in;
   cvl_status_type       status_ff, status_in;
   logic [IDX_W-1:0]     index_ff, index_in;
   logic [CNT_W-1:0]     occ_ff;
   logic                 full;
   logic                 empty;
   logic                 do_append;
   logic                 do_delete;
   logic                 do_modify;
   logic [31:0]          index_wide;
   logic [31:0]          occ_wide;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         command_ff   <= cvl_cmd_type'(req_command);
         key_ff       <= req_value;
         new_value_ff <= req_new_value;
      end
   end

   // Every held entry is compared against the key at once.
   always_comb begin
      match_in = '0;
      for (int j = 0; j < DEPTH; j++) begin
         match_in[j] = (entries_ff[j] == key_ff) && (j < int'(count_ff));
      end
   end

   // First level of the first-match tree: one priority encoder per group.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_hit_in[g] = |match_ff[g*GROUP_SIZE +: GROUP_SIZE];
         group_loc_in[g] = '0;
         for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (match_ff[g*GROUP_SIZE + k]) begin
               group_loc_in[g] = LOC_W'(k);
            end
         end
      end
   end

   // Second level: the lowest group that holds a match.
   always_comb begin
      hit_in       = |group_hit_ff;
      hit_index_in = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (group_hit_ff[g]) begin
            hit_index_in = IDX_W'(g * GROUP_SIZE + int'(group_loc_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.match) begin
         match_ff <= match_in;
      end
      if (ctrl.group) begin
         group_hit_ff <= group_hit_in;
         group_loc_ff <= group_loc_in;
      end
      if (ctrl.resolve) begin
         hit_ff       <= hit_in;
         hit_index_ff <= hit_index_in;
      end
   end

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      do_append = 1'b0;
      do_delete = 1'b0;
      do_modify = 1'b0;
      status_in = ST_OK;
      index_in  = '0;
      count_in  = count_ff;
      if (command_ff == CMD_APPEND) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            do_append = 1'b1;
            index_in  = IDX_W'(count_ff);
            count_in  = count_ff + 1'b1;
         end
      end else if (empty) begin
         status_in = ST_EMPTY;
      end else if (!hit_ff) begin
         status_in = ST_NOMATCH;
      end else begin
         index_in = hit_index_ff;
         case (command_ff)
            CMD_DELETE: begin
               do_delete = 1'b1;
               count_in  = count_ff - 1'b1;
            end
            CMD_MODIFY: begin
               do_modify = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Each cell takes its neighbor above on a delete, the key on an append at
   // its place, or the replacement on a modify of its own entry.
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic [VALUE_W-1:0] upper;
      if (j < DEPTH - 1) begin : g_upper
         assign upper = entries_ff[j+1];
      end else begin : g_top
         assign upper = entries_ff[j];
      end
      always_ff @(posedge clock) begin
         if (ctrl.commit) begin
            if (do_append && (j == int'(count_ff))) begin
               entries_ff[j] <= key_ff;
            end else if (do_modify && (j == int'(hit_index_ff))) begin
               entries_ff[j] <= new_value_ff;
            end else if (do_delete && (j >= int'(hit_index_ff))
                         && (j + 1 < int'(count_ff))) begin
               entries_ff[j] <= upper;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         occ_ff    <= count_in;
      end
   end

   assign index_wide      = 32'(index_ff);
   assign occ_wide        = 32'(occ_ff);
   assign rsp_status      = status_ff;
   assign rsp_match_index = index_wide[INDEX_OUT_W-1:0];
   assign rsp_occupancy   = occ_wide[OCC_OUT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/cvl_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_controller
// Sequences one command through compare, encode, resolve and commit steps.
// ----------------------------------------------------------------------------
module cvl_controller
   import cvl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output cvl_ctrl_type ctrl
);

   cvl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_MATCH;
            end
         end
         S_MATCH: begin
            ctrl.match = 1'b1;
            state_in   = S_GROUP;
         end
         S_GROUP: begin
            ctrl.group = 1'b1;
            state_in   = S_RESOLVE;
         end
         S_RESOLVE: begin
            ctrl.resolve = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            // The result register must be free or emptied in this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.commit  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/compacting_value_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_value_list
// Dense ordered list of signed 32-bit values with append, delete, search and
// modify commands.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction enters on the req_ channel (command, value,
// new_value) and one result transaction leaves on the rsp_ channel (status,
// match_index, occupancy). Both channels use valid/ready.
// The result of a command is presented after these steps: the capture at
// acceptance is followed by a parallel compare of all entry cells, two
// levels of a registered first-match priority tree and a commit that updates
// the cells and count.
// A new command is taken only once the previous command has committed.
// A delete shifts all later cells down by one place in the commit cycle.
// The result sits in an output register, so the next command is accepted
// while an earlier result is still waiting. If the receiver stalls, the
// commit of that next command waits until the result register is free.
// Reset empties the list and clears the control state; entry contents are
// not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module compacting_value_list
   import cvl_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [COMMAND_W-1:0]      req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic signed [VALUE_W-1:0] req_new_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [INDEX_OUT_W-1:0]    rsp_match_index,
   output logic [OCC_OUT_W-1:0]      rsp_occupancy
);

   cvl_ctrl_type ctrl;

   cvl_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   cvl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_command     (req_command),
      .req_value       (req_value),
      .req_new_value   (req_new_value),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule
`default_nettype wire

// ===== sv/cvl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_checker
// Port-level checks for the compacting value list.
// ----------------------------------------------------------------------------
module cvl_checker
   import cvl_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [STATUS_W-1:0]    rsp_status,
   input  logic [INDEX_OUT_W-1:0] rsp_match_index,
   input  logic [OCC_OUT_W-1:0]   rsp_occupancy
);

   // The block works on one transaction at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("command accepted while another is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_match_index == '0))
      else $error("failed command reports a nonzero index");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_occupancy) <= DEPTH))
      else $error("occupancy above capacity");

endmodule

bind compacting_value_list cvl_checker #(
   .DEPTH (DEPTH)
) u_cvl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_match_index (rsp_match_index),
   .rsp_occupancy   (rsp_occupancy)
);
`default_nettype wire

// ===== tb/compacting_value_list_test.sv =====
// ----------------------------------------------------------------------------
// compacting_value_list_test
// Self-checking testbench for the compacting value list. A scoreboard keeps
// its own copy of the list and predicts the status, index and occupancy of
// every command. A short directed sequence is followed by random rounds that
// fill the list to capacity, mix all four commands and drain it to empty.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module compacting_value_list_test;
   import cvl_pkg::*;

   localparam int LIST_DEPTH   = 128;
   localparam int ITEM_TARGET  = 800;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_WAIT  = 20;

   typedef struct packed {
      cvl_status_type               status;
      logic [INDEX_OUT_W-1:0]       match_index;
      logic [OCC_OUT_W-1:0]         occupancy;
   } list_result_type;

   class value_list_scoreboard;
      logic [VALUE_W-1:0] held [LIST_DEPTH];
      int unsigned        held_count;
      list_result_type    expected [$];
      int unsigned        failures;

      function new();
         held_count = 0;
         failures   = 0;
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      function void note_command(cvl_cmd_type cmd, logic [VALUE_W-1:0] key,
                                 logic [VALUE_W-1:0] repl);
         list_result_type r;
         int              hit;
         int              i;
         r.status      = ST_OK;
         r.match_index = '0;
         hit = -1;
         for (i = 0; i < held_count; i++) begin
            if (hit < 0 && held[i] == key) hit = i;
         end
         if (cmd == CMD_APPEND) begin
            if (held_count == LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held[held_count] = key;
               r.match_index    = INDEX_OUT_W'(held_count);
               held_count++;
            end
         end else if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else if (hit < 0) begin
            r.status = ST_NOMATCH;
         end else begin
            r.match_index = INDEX_OUT_W'(hit);
            if (cmd == CMD_DELETE) begin
               for (i = hit; i + 1 < held_count; i++) held[i] = held[i + 1];
               held_count--;
            end else if (cmd == CMD_MODIFY) begin
               held[hit] = repl;
            end
         end
         r.occupancy = OCC_OUT_W'(held_count);
         expected.push_back(r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status,
                                 logic [INDEX_OUT_W-1:0] match_index,
                                 logic [OCC_OUT_W-1:0] occupancy);
         list_result_type e;
         if (expected.size() == 0) begin
            $display("%0t: result with none expected: status %0d index %0d occupancy %0d",
                     $time, status, match_index, occupancy);
            failures++;
            return;
         end
         e = expected.pop_front();
         if (status !== e.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, e.status, status);
            failures++;
         end
         if (match_index !== e.match_index) begin
            $display("%0t: match_index mismatch: expected %0d, actual %0d",
                     $time, e.match_index, match_index);
            failures++;
         end
         if (occupancy !== e.occupancy) begin
            $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                     $time, e.occupancy, occupancy);
            failures++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [COMMAND_W-1:0]      req_command;
   logic signed [VALUE_W-1:0] req_value;
   logic signed [VALUE_W-1:0] req_new_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STATUS_W-1:0]       rsp_status;
   logic [INDEX_OUT_W-1:0]    rsp_match_index;
   logic [OCC_OUT_W-1:0]      rsp_occupancy;

   value_list_scoreboard list_sb = new();
   int  idle_cycles = 0;
   int  items_sent  = 0;
   bit  steady_req  = 0;
   bit  steady_rsp  = 0;

   compacting_value_list #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_match_index(rsp_match_index),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pool_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return VALUE_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      if ($urandom_range(0, 3) == 0) return pool_value();
      return $urandom;
   endfunction

   function automatic logic [VALUE_W-1:0] held_key();
      if (list_sb.held_count == 0) return random_value();
      return list_sb.held[$urandom_range(0, list_sb.held_count - 1)];
   endfunction

   task automatic send_command(cvl_cmd_type cmd, logic [VALUE_W-1:0] value,
                               logic [VALUE_W-1:0] new_value);
      int gap;
      gap = steady_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_value     <= value;
      req_new_value <= new_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      list_sb.note_command(cmd, value, new_value);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (list_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic fill_round();
      while (list_sb.held_count < LIST_DEPTH) send_command(CMD_APPEND, random_value(), 0);
      repeat ($urandom_range(1, 3)) send_command(CMD_APPEND, random_value(), $urandom);
      send_command(CMD_SEARCH, held_key(), 0);
   endtask

   task automatic mixed_round();
      logic [VALUE_W-1:0] key;
      repeat (40) begin
         key = ($urandom_range(0, 3) != 0) ? held_key() : random_value();
         send_command(cvl_cmd_type'($urandom_range(0, 3)), key, random_value());
      end
   endtask

   task automatic drain_round();
      while (list_sb.held_count > 0) begin
         if ($urandom_range(0, 4) == 0) send_command(CMD_SEARCH, held_key(), 0);
         send_command(CMD_DELETE, held_key(), $urandom);
      end
      send_command(cvl_cmd_type'($urandom_range(1, 3)), random_value(), random_value());
   endtask

   initial begin
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (steady_rsp) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            int stall;
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         list_sb.check_result(rsp_status, rsp_match_index, rsp_occupancy);
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int  round;
      int  mode;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_command   <= CMD_APPEND;
      req_value     <= '0;
      req_new_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Commands on an empty list, then a short list with a duplicate value.
      send_command(CMD_DELETE, 32'h0000_0000, 32'h0000_0000);
      send_command(CMD_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);
      send_command(CMD_MODIFY, 32'h7FFF_FFFF, 32'h1234_5678);
      send_command(CMD_APPEND, 32'h8000_0000, 32'h0000_0000);
      send_command(CMD_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_command(CMD_APPEND, 32'h0000_0000, 32'h8000_0000);
      send_command(CMD_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_command(CMD_APPEND, 32'h7FFF_FFFF, 32'h0000_0000);
      send_command(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
      send_command(CMD_SEARCH, 32'h0000_3039, 32'h0000_0000);
      send_command(CMD_MODIFY, 32'h0000_3039, 32'hAAAA_AAAA);
      send_command(CMD_SEARCH, 32'hAAAA_AAAA, 32'h0000_0000);
      send_command(CMD_MODIFY, 32'h7FFF_FFFF, 32'h5555_5555);
      send_command(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
      send_command(CMD_DELETE, 32'h8000_0000, 32'h0000_0000);
      send_command(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
      send_command(CMD_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_command(CMD_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_command(CMD_DELETE, 32'h5555_5555, 32'h0000_0000);
      send_command(CMD_DELETE, 32'h0000_0000, 32'h0000_0000);
      send_command(CMD_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
      send_command(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);

      round = 0;
      while (items_sent < ITEM_TARGET) begin
         steady_req = ($urandom_range(0, 3) == 0);
         steady_rsp = ($urandom_range(0, 3) == 0);
         mode = (round == 0) ? 0 : $urandom_range(0, 9);
         if (mode < 2) fill_round();
         else if (mode < 8) mixed_round();
         else drain_round();
         if (round == 0 || $urandom_range(0, 3) == 0) wait_for_results();
         round++;
      end

      req_valid <= 1'b0;
      while (list_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (list_sb.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
